FILE: src/jse_pkg.sv
// Shared types, constants and a helper function for the JSON string byte escaper.
`default_nettype none
package jse_pkg;

    localparam int CFG_W              = 17;
    localparam int LEN_W              = 17;
    localparam int OFF_W              = 16;
    localparam int MAX_SEQ            = 6;
    localparam int CNT_W              = 3;
    localparam int BUFFER_BYTES_DFLT  = 65536;
    localparam int OFFSET_SPAN        = 65536;
    localparam logic [CFG_W-1:0] CAPACITY_RESET = 17'd65536;

    typedef enum logic [1:0] {
        FUNC_ESC     = 2'd0,
        FUNC_RAW     = 2'd1,
        FUNC_RESTART = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CTRL_LIM = 8'h20;

    typedef struct packed {
        logic [MAX_SEQ-1:0][7:0] chars;
        logic [CNT_W-1:0]        count;
    } t_seq;

    function automatic logic [7:0] hex_nibble(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = CH_ZERO + {4'd0, v};
        end else begin
            r = CH_A + {4'd0, v} - 8'd10;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/json_string_byte_escaper.sv
// Top level of the JSON string byte escaper with length tracking against capacity.
// An accepted byte is held in the input register and, once the output is free, loaded into
// the output register, from which its first result is presented.
// Throughput: one input per cycle for one-result bytes while the output is not stalled;
// an escape of n characters holds the output, sent one character per cycle while tready is high.
// Reset (synchronous, active low) empties both stages, clears the length and sets capacity
// to its reset value.
`default_nettype none
module json_string_byte_escaper #(
    parameter int BUFFER_BYTES = jse_pkg::BUFFER_BYTES_DFLT
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [jse_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                     i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  wire logic [7:0]               i_s_axis_tdata,   // data_byte
    input  wire logic [1:0]               i_s_axis_tuser,   // func
    output logic                          o_m_axis_tvalid,
    input  wire logic                     i_m_axis_tready,
    output logic [23:0]                   o_m_axis_tdata,   // out_byte, write_offset
    output logic [1:0]                    o_m_axis_tuser,   // char_valid, status
    output logic                          o_m_axis_tlast
);
    import jse_pkg::*;

    localparam int CapLim = (BUFFER_BYTES < OFFSET_SPAN) ? BUFFER_BYTES : OFFSET_SPAN;
    localparam logic [CFG_W-1:0] CapLimV = CFG_W'(CapLim);

    logic [CFG_W-1:0]        r_cap;
    logic [LEN_W-1:0]        r_used,  n_used;

    logic                    r_in_valid;
    t_func                   r_in_func;
    logic [7:0]              r_in_byte;

    logic                    r_out_valid, n_out_valid;
    logic [MAX_SEQ-1:0][7:0] r_chars, n_chars;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [OFF_W-1:0]        r_off, n_off;
    logic                    r_char_valid, n_char_valid;
    logic                    r_status, n_status;

    t_seq                    enc_seq;
    logic [CFG_W-1:0]        cap_eff;
    logic                    fits;
    logic                    out_fire, last_fire, load;

    jse_encoder u_encoder (
        .i_raw  (r_in_func == FUNC_RAW),
        .i_byte (r_in_byte),
        .o_seq  (enc_seq)
    );

    assign o_cfg_ready     = 1'b1;
    assign cap_eff         = (r_cap > CapLimV) ? CapLimV : r_cap;
    assign fits            = ({1'b0, r_used} + {{(LEN_W+1-CNT_W){1'b0}}, enc_seq.count})
                             <= {1'b0, cap_eff};

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_off, r_chars[r_idx]};
    assign o_m_axis_tuser  = {r_status, r_char_valid};
    assign o_m_axis_tlast  = (r_idx == r_cnt - 3'd1);

    assign out_fire        = r_out_valid && i_m_axis_tready;
    assign last_fire       = out_fire && o_m_axis_tlast;
    assign load            = r_in_valid && (r_in_func == FUNC_NONE || !r_out_valid || last_fire);
    assign o_s_axis_tready = !r_in_valid || load;

    always_comb begin
        n_used       = r_used;
        n_out_valid  = r_out_valid;
        n_chars      = r_chars;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_off        = r_off;
        n_char_valid = r_char_valid;
        n_status     = r_status;
        if (load && r_in_func != FUNC_NONE) begin
            n_out_valid  = 1'b1;
            n_idx        = '0;
            n_chars      = '0;
            n_cnt        = 3'd1;
            n_off        = '0;
            n_char_valid = 1'b0;
            n_status     = 1'b0;
            if (r_in_func == FUNC_RESTART) begin
                n_used = '0;
            end else if (fits) begin
                n_chars      = enc_seq.chars;
                n_cnt        = enc_seq.count;
                n_off        = r_used[OFF_W-1:0];
                n_char_valid = 1'b1;
                n_used       = r_used + {{(LEN_W-CNT_W){1'b0}}, enc_seq.count};
            end else begin
                n_status = 1'b1;
            end
        end else if (last_fire) begin
            n_out_valid = 1'b0;
        end else if (out_fire) begin
            n_idx = r_idx + 3'd1;
            n_off = r_off + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAPACITY_RESET;
            r_used      <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_func <= t_func'(i_s_axis_tuser);
            r_in_byte <= i_s_axis_tdata;
        end
        r_chars      <= n_chars;
        r_cnt        <= n_cnt;
        r_idx        <= n_idx;
        r_off        <= n_off;
        r_char_valid <= n_char_valid;
        r_status     <= n_status;
    end

endmodule
`default_nettype wire

FILE: src/jse_encoder.sv
// Combinational escape encoder: turns one byte into its output character sequence.
`default_nettype none
module jse_encoder (
    input  wire logic          i_raw,
    input  wire logic [7:0]    i_byte,
    output jse_pkg::t_seq      o_seq
);
    import jse_pkg::*;

    always_comb begin
        o_seq = '0;
        if (i_raw) begin
            o_seq.chars[0] = i_byte;
            o_seq.count    = 3'd1;
        end else if (i_byte == CH_QUOTE || i_byte == CH_BSL) begin
            o_seq.chars[0] = CH_BSL;
            o_seq.chars[1] = i_byte;
            o_seq.count    = 3'd2;
        end else if (i_byte == CH_LF) begin
            o_seq.chars[0] = CH_BSL;
            o_seq.chars[1] = CH_N;
            o_seq.count    = 3'd2;
        end else if (i_byte == CH_CR) begin
            o_seq.chars[0] = CH_BSL;
            o_seq.chars[1] = CH_R;
            o_seq.count    = 3'd2;
        end else if (i_byte == CH_TAB) begin
            o_seq.chars[0] = CH_BSL;
            o_seq.chars[1] = CH_T;
            o_seq.count    = 3'd2;
        end else if (i_byte < CTRL_LIM) begin
            o_seq.chars[0] = CH_BSL;
            o_seq.chars[1] = CH_U;
            o_seq.chars[2] = CH_ZERO;
            o_seq.chars[3] = CH_ZERO;
            o_seq.chars[4] = hex_nibble(i_byte[7:4]);
            o_seq.chars[5] = hex_nibble(i_byte[3:0]);
            o_seq.count    = 3'd6;
        end else begin
            o_seq.chars[0] = i_byte;
            o_seq.count    = 3'd1;
        end
    end

endmodule
`default_nettype wire
